[design/xtb_pkg.sv]
// ----------------------------------------------------------------------------
// XTEA padded block cipher: shared package
// Request codes, pipeline sideband type, key type and cipher constants.
// ----------------------------------------------------------------------------
`default_nettype none

package xtb_pkg;

  localparam logic [31:0] XtbDelta    = 32'h9E37_79B9;
  localparam int          XtbKeyWords = 4;
  localparam logic [3:0]  XtbBlkBytes = 4'd8;

  typedef enum logic {
    XTB_ENC = 1'b0,
    XTB_DEC = 1'b1
  } xtb_req_e;

  // Sideband that travels with each beat through the round pipeline
  typedef struct packed {
    xtb_req_e req;
    logic     last;
  } xtb_ctl_t;

  typedef logic [XtbKeyWords-1:0][31:0] xtb_key_t;

endpackage

`default_nettype wire

[design/xtea_block_cipher_padded_top.sv]
// ----------------------------------------------------------------------------
// XTEA padded block cipher: top level
// Fully pipelined XTEA encrypt/decrypt of 64-bit blocks with PKCS#7-style
// tail padding on encrypt and pad count checking on decrypt.
// ----------------------------------------------------------------------------
// A block is taken on every cycle that start_i is high (busy_o is always low)
// and its result appears on the result ports with done_o high after it has
// passed one pad stage, one registered stage per half-round and one unpad
// stage. Throughput is one block per clock; the receiver cannot stall, so
// results must be taken as they appear. Write the key words only while no
// block is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_cipher_padded_top #(
  parameter int ROUNDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [63:0] data_block_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_block_i,
  output logic        done_o,
  output logic [63:0] result_block_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_out_o,
  output logic        pad_error_o
);
  import xtb_pkg::*;

  localparam int Stages = 2 * ROUNDS;

  xtb_key_t    key_q;
  xtb_ctl_t    in_ctl;
  logic        in_valid;

  logic        st_valid [Stages+1];
  xtb_ctl_t    st_ctl   [Stages+1];
  logic [31:0] st_v0    [Stages+1];
  logic [31:0] st_v1    [Stages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  assign busy_o      = 1'b0;
  assign in_valid    = start_i && !busy_o;
  assign in_ctl.req  = xtb_req_e'(req_type_i);
  assign in_ctl.last = last_block_i;

  xtb_pad u_pad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ctl_i   (in_ctl),
    .data_i  (data_block_i),
    .count_i (byte_count_i),
    .valid_o (st_valid[0]),
    .ctl_o   (st_ctl[0]),
    .v0_o    (st_v0[0]),
    .v1_o    (st_v1[0])
  );

  for (genvar j = 0; j < Stages; j++) begin : g_round
    localparam int          Rnd     = j / 2;
    localparam bit          Second  = (j % 2) == 1;
    localparam int          EncMult = Second ? Rnd + 1 : Rnd;
    localparam int          DecMult = Second ? ROUNDS - Rnd - 1 : ROUNDS - Rnd;
    localparam logic [63:0] EncProd = 64'(XtbDelta) * 64'(EncMult);
    localparam logic [63:0] DecProd = 64'(XtbDelta) * 64'(DecMult);
    localparam logic [31:0] EncSum  = EncProd[31:0];
    localparam logic [31:0] DecSum  = DecProd[31:0];
    // first half of a cycle keys on sum bits 1:0 for encrypt, 12:11 for decrypt
    localparam logic [1:0]  EncKidx = Second ? EncSum[12:11] : EncSum[1:0];
    localparam logic [1:0]  DecKidx = Second ? DecSum[1:0] : DecSum[12:11];

    xtb_round #(
      .ENC_SUM  (EncSum),
      .ENC_KIDX (EncKidx),
      .DEC_SUM  (DecSum),
      .DEC_KIDX (DecKidx),
      .SECOND   (Second)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (st_valid[j]),
      .ctl_i   (st_ctl[j]),
      .v0_i    (st_v0[j]),
      .v1_i    (st_v1[j]),
      .valid_o (st_valid[j+1]),
      .ctl_o   (st_ctl[j+1]),
      .v0_o    (st_v0[j+1]),
      .v1_o    (st_v1[j+1])
    );
  end

  xtb_unpad u_unpad (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (st_valid[Stages]),
    .ctl_i         (st_ctl[Stages]),
    .v0_i          (st_v0[Stages]),
    .v1_i          (st_v1[Stages]),
    .done_o        (done_o),
    .result_o      (result_block_o),
    .valid_bytes_o (valid_bytes_o),
    .last_o        (last_out_o),
    .pad_error_o   (pad_error_o)
  );

endmodule

`default_nettype wire

[design/xtb_pad.sv]
// ----------------------------------------------------------------------------
// XTEA padded block cipher: pad stage
// Fills the tail of a last encrypt block with the pad count and registers
// the block as the two cipher words.
// ----------------------------------------------------------------------------
`default_nettype none

module xtb_pad (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  xtb_pkg::xtb_ctl_t ctl_i,
  input  logic [63:0]      data_i,
  input  logic [3:0]       count_i,
  output logic             valid_o,
  output xtb_pkg::xtb_ctl_t ctl_o,
  output logic [31:0]      v0_o,
  output logic [31:0]      v1_o
);
  import xtb_pkg::*;

  logic        valid_q;
  xtb_ctl_t    ctl_q;
  logic [63:0] blk_q;
  logic [63:0] blk_d;
  logic [7:0]  pad_val;
  logic        do_pad;

  assign do_pad  = (ctl_i.req == XTB_ENC) && ctl_i.last && (count_i < XtbBlkBytes);
  assign pad_val = {4'd0, XtbBlkBytes - count_i};

  // byte b sits in bits (7-b)*8 +: 8; replace every byte at or past the count
  always_comb begin
    blk_d = data_i;
    for (int b = 0; b < 8; b++) begin
      if (do_pad && (4'(b) >= count_i)) begin
        blk_d[(7-b)*8 +: 8] = pad_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    blk_q <= blk_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign v0_o    = blk_q[63:32];
  assign v1_o    = blk_q[31:0];

endmodule

`default_nettype wire

[design/xtb_round.sv]
// ----------------------------------------------------------------------------
// XTEA padded block cipher: half-round stage
// One registered Feistel half-round. Encrypt adds into one word, decrypt
// subtracts from the other; schedule sums and key selects are fixed per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xtb_round #(
  parameter logic [31:0] ENC_SUM  = 32'd0,
  parameter logic [1:0]  ENC_KIDX = 2'd0,
  parameter logic [31:0] DEC_SUM  = 32'd0,
  parameter logic [1:0]  DEC_KIDX = 2'd0,
  parameter bit          SECOND   = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xtb_pkg::xtb_key_t key_i,
  input  logic              valid_i,
  input  xtb_pkg::xtb_ctl_t ctl_i,
  input  logic [31:0]       v0_i,
  input  logic [31:0]       v1_i,
  output logic              valid_o,
  output xtb_pkg::xtb_ctl_t ctl_o,
  output logic [31:0]       v0_o,
  output logic [31:0]       v1_o
);
  import xtb_pkg::*;

  logic        valid_q;
  xtb_ctl_t    ctl_q;
  logic [31:0] v0_q, v0_d;
  logic [31:0] v1_q, v1_d;
  logic        dec;
  logic        upd_v1;
  logic [31:0] upd_w, src_w, mix_w, sk_w, f_w, new_w;

  assign dec    = (ctl_i.req == XTB_DEC);
  // encrypt updates v0 on the first half of a cycle and v1 on the second,
  // decrypt the reverse
  assign upd_v1 = dec ^ SECOND;

  assign upd_w = upd_v1 ? v1_i : v0_i;
  assign src_w = upd_v1 ? v0_i : v1_i;
  assign mix_w = ((src_w << 4) ^ (src_w >> 5)) + src_w;
  assign sk_w  = dec ? (DEC_SUM + key_i[DEC_KIDX]) : (ENC_SUM + key_i[ENC_KIDX]);
  assign f_w   = mix_w ^ sk_w;
  assign new_w = dec ? (upd_w - f_w) : (upd_w + f_w);

  assign v0_d = upd_v1 ? v0_i : new_w;
  assign v1_d = upd_v1 ? new_w : v1_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    v0_q  <= v0_d;
    v1_q  <= v1_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign v0_o    = v0_q;
  assign v1_o    = v1_q;

endmodule

`default_nettype wire

[design/xtb_unpad.sv]
// ----------------------------------------------------------------------------
// XTEA padded block cipher: unpad stage
// Reads the pad count from the last byte of a final decrypted block,
// derives the valid byte count and error flag, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module xtb_unpad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  xtb_pkg::xtb_ctl_t ctl_i,
  input  logic [31:0]       v0_i,
  input  logic [31:0]       v1_i,
  output logic              done_o,
  output logic [63:0]       result_o,
  output logic [3:0]        valid_bytes_o,
  output logic              last_o,
  output logic              pad_error_o
);
  import xtb_pkg::*;

  logic        done_q;
  logic [63:0] res_q;
  logic [3:0]  vbytes_q, vbytes_d;
  logic        last_q;
  logic        err_q, err_d;
  logic [7:0]  pad_cnt;

  assign pad_cnt = v1_i[7:0];

  always_comb begin
    vbytes_d = XtbBlkBytes;
    err_d    = 1'b0;
    if ((ctl_i.req == XTB_DEC) && ctl_i.last) begin
      if (pad_cnt == 8'd0) begin
        vbytes_d = XtbBlkBytes;
      end else if (pad_cnt <= {4'd0, XtbBlkBytes}) begin
        vbytes_d = XtbBlkBytes - pad_cnt[3:0];
      end else begin
        vbytes_d = 4'd0;
        err_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= {v0_i, v1_i};
    vbytes_q <= vbytes_d;
    last_q   <= ctl_i.last;
    err_q    <= err_d;
  end

  assign done_o        = done_q;
  assign result_o      = res_q;
  assign valid_bytes_o = vbytes_q;
  assign last_o        = last_q;
  assign pad_error_o   = err_q;

endmodule

`default_nettype wire
